// File: rtl/mtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

  localparam int IN_SLOT_W = 4;
  localparam int TIME_W    = 32;

  localparam logic [1:0] REQ_DECLARE = 2'd0;
  localparam logic [1:0] REQ_CANCEL  = 2'd1;
  localparam logic [1:0] REQ_EXPIRE  = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_NOT_ACTIVE = 2'd2;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd1000000;

  // commands from the controller to the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FIND,
    OP_DSUM,
    OP_DARM,
    OP_DREL,
    OP_CANCEL,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_COMMIT,
    OP_STATUS
  } op_t;

  typedef struct packed {
    logic [1:0] req;
    logic       cur_free;
    logic       idx_last;
    logic       cancel_bad;
    logic       cancel_next;
    logic       present;
    logic       earlier;
    logic       out_free;
    logic       scan_step;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/mtt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mtt_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [1:0]              req_type,
  input  mtt_pkg::dp_status_t     st,
  output mtt_pkg::op_t            op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DSUM,
    S_DDEC,
    S_CANCEL,
    S_SCAN_PRE,
    S_SCAN,
    S_SCAN_END,
    S_STATUS
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    op         = mtt_pkg::OP_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = mtt_pkg::OP_ACCEPT;
          unique case (req_type)
            mtt_pkg::REQ_DECLARE: state_next = S_FIND;
            mtt_pkg::REQ_CANCEL:  state_next = S_CANCEL;
            mtt_pkg::REQ_EXPIRE:  state_next = S_SCAN_PRE;
            default:              state_next = S_STATUS;
          endcase
        end
      end
      S_FIND: begin
        op = mtt_pkg::OP_FIND;
        priority if (st.cur_free) begin
          state_next = S_DSUM;
        end else if (st.idx_last) begin
          state_next = S_STATUS;
        end else begin
          state_next = S_FIND;
        end
      end
      S_DSUM: begin
        op         = mtt_pkg::OP_DSUM;
        state_next = S_DDEC;
      end
      S_DDEC: begin
        priority if (!st.present) begin
          op         = mtt_pkg::OP_DARM;
          state_next = S_STATUS;
        end else if (st.earlier) begin
          state_next = S_SCAN_PRE;
        end else begin
          op         = mtt_pkg::OP_DREL;
          state_next = S_STATUS;
        end
      end
      S_CANCEL: begin
        op = mtt_pkg::OP_CANCEL;
        priority if (st.cancel_bad) begin
          state_next = S_STATUS;
        end else if (st.cancel_next) begin
          state_next = S_SCAN_PRE;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_SCAN_PRE: begin
        op         = mtt_pkg::OP_SCAN_INIT;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        op = mtt_pkg::OP_SCAN;
        if (st.scan_step && st.idx_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // an earlier declare arms on its own slot after aging
        op = (st.req == mtt_pkg::REQ_DECLARE) ? mtt_pkg::OP_DARM : mtt_pkg::OP_COMMIT;
        state_next = S_STATUS;
      end
      S_STATUS: begin
        op = mtt_pkg::OP_STATUS;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mtt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mtt_datapath #(
  parameter int NUM_SLOTS = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  mtt_pkg::op_t            op,
  output mtt_pkg::dp_status_t     st,
  input  wire  [1:0]              req_type,
  input  wire  [31:0]             duration,
  input  wire  [3:0]              slot,
  input  wire  [31:0]             now,
  input  wire                     cfg_wr_en,
  input  wire  [31:0]             cfg_wr_data,
  input  wire                     out_ready,
  output logic                    out_valid,
  output logic                    kind,
  output logic [3:0]              slot_out,
  output logic [1:0]              status,
  output logic                    armed,
  output logic [31:0]             reload,
  output logic                    rearmed,
  output logic                    last
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // request word
  logic [1:0]        req_r;
  logic [31:0]       dur_r;
  logic [3:0]        cslot_r;
  logic [31:0]       now_r;
  logic [31:0]       elapsed_r;
  logic [31:0]       dn_sum;
  logic [31:0]       nb_sum;

  // table state
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [31:0]          rem_mem [NUM_SLOTS];
  logic [31:0]          rdata;
  logic [31:0]          armed_at;
  logic [SLOT_W-1:0]    next_slot;
  logic                 next_present;
  logic [31:0]          limit;

  // scan and result state
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] free_idx;
  logic [31:0]       best;
  logic [SLOT_W-1:0] pick;
  logic              found;
  logic [1:0]        stat_r;
  logic [3:0]        res_slot;
  logic [31:0]       reload_r;
  logic              rearmed_r;

  logic              live;
  logic              hit;
  logic [31:0]       aged;
  logic              expire;
  logic              out_free;
  logic              scan_step;
  logic              idx_last;
  logic [31:0]       idx_ext;
  logic [3:0]        idx4;
  logic [31:0]       cslot_ext;
  logic [SLOT_W-1:0] cidx;
  logic              c_in_range;
  logic              cancel_bad;
  logic              cancel_next;
  logic [SLOT_W-1:0] rd_addr;
  logic              we;
  logic [SLOT_W-1:0] wa;
  logic [31:0]       wd;
  logic              load_exp;
  logic              load_st;

  assign live      = slot_valid[idx];
  assign hit       = elapsed_r < rdata;
  assign aged      = rdata - elapsed_r;
  assign expire    = live && !hit;
  assign out_free  = !out_valid || out_ready;
  // an expiring slot waits until its notice can go out
  assign scan_step = !expire || out_free;
  assign idx_last  = (idx == SLOT_W'(NUM_SLOTS - 1));
  assign idx_ext   = 32'(idx);
  assign idx4      = idx_ext[3:0];

  assign cslot_ext   = 32'(cslot_r);
  assign cidx        = cslot_ext[SLOT_W-1:0];
  assign c_in_range  = cslot_ext < 32'(NUM_SLOTS);
  assign cancel_bad  = !c_in_range || !slot_valid[cidx];
  assign cancel_next = next_present && (next_slot == cidx);

  assign load_exp = (op == mtt_pkg::OP_SCAN) && expire && out_free;
  assign load_st  = (op == mtt_pkg::OP_STATUS) && out_free;

  assign st.req         = req_r;
  assign st.cur_free    = !live;
  assign st.idx_last    = idx_last;
  assign st.cancel_bad  = cancel_bad;
  assign st.cancel_next = cancel_next;
  assign st.present     = next_present;
  assign st.earlier     = dn_sum < nb_sum;
  assign st.out_free    = out_free;
  assign st.scan_step   = scan_step;

  // read address leads the scan index by one so a word is ready each cycle
  always_comb begin
    unique case (op)
      mtt_pkg::OP_FIND: rd_addr = next_slot;
      mtt_pkg::OP_SCAN: rd_addr = (scan_step && !idx_last) ? idx + SLOT_W'(1) : idx;
      default:          rd_addr = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = aged;
    unique case (op)
      mtt_pkg::OP_SCAN: begin
        we = scan_step && live && hit;
      end
      mtt_pkg::OP_DARM: begin
        we = 1'b1;
        wa = free_idx;
        wd = dur_r;
      end
      mtt_pkg::OP_DREL: begin
        // stored relative to the arming time
        we = 1'b1;
        wa = free_idx;
        wd = dur_r + elapsed_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= rem_mem[rd_addr];
    if (we) begin
      rem_mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      next_slot    <= '0;
      next_present <= 1'b0;
      armed_at     <= '0;
      limit        <= mtt_pkg::LIMIT_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      if (load_exp || load_st) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        mtt_pkg::OP_CANCEL: begin
          if (!cancel_bad) begin
            slot_valid[cidx] <= 1'b0;
          end
        end
        mtt_pkg::OP_SCAN: begin
          if (scan_step && expire) begin
            slot_valid[idx] <= 1'b0;
          end
        end
        mtt_pkg::OP_DARM: begin
          slot_valid[free_idx] <= 1'b1;
          armed_at             <= now_r;
          next_slot            <= free_idx;
          next_present         <= 1'b1;
        end
        mtt_pkg::OP_DREL: begin
          slot_valid[free_idx] <= 1'b1;
        end
        mtt_pkg::OP_COMMIT: begin
          next_present <= found;
          next_slot    <= found ? pick : '0;
          if (found) begin
            armed_at <= now_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      mtt_pkg::OP_ACCEPT: begin
        req_r     <= req_type;
        dur_r     <= duration;
        cslot_r   <= slot;
        now_r     <= now;
        elapsed_r <= now - armed_at;
        dn_sum    <= duration + now;
        idx       <= '0;
        stat_r    <= mtt_pkg::STAT_OK;
        res_slot  <= '0;
        reload_r  <= '0;
        rearmed_r <= 1'b0;
      end
      mtt_pkg::OP_FIND: begin
        if (!live) begin
          free_idx <= idx;
          res_slot <= idx4;
        end else if (idx_last) begin
          stat_r <= mtt_pkg::STAT_FULL;
        end
        if (!idx_last) begin
          idx <= idx + SLOT_W'(1);
        end
      end
      mtt_pkg::OP_DSUM: begin
        nb_sum <= rdata + armed_at;
      end
      mtt_pkg::OP_CANCEL: begin
        if (cancel_bad) begin
          stat_r <= mtt_pkg::STAT_NOT_ACTIVE;
        end
      end
      mtt_pkg::OP_SCAN_INIT: begin
        idx   <= '0;
        best  <= limit;
        pick  <= '0;
        found <= 1'b0;
      end
      mtt_pkg::OP_SCAN: begin
        if (scan_step) begin
          if (live && hit && (aged < best)) begin
            best  <= aged;
            pick  <= idx;
            found <= 1'b1;
          end
          if (!idx_last) begin
            idx <= idx + SLOT_W'(1);
          end
        end
      end
      mtt_pkg::OP_DARM: begin
        reload_r  <= dur_r;
        rearmed_r <= 1'b1;
      end
      mtt_pkg::OP_COMMIT: begin
        if (found) begin
          reload_r  <= best;
          rearmed_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase

    priority if (load_exp) begin
      kind     <= mtt_pkg::KIND_EXPIRY;
      slot_out <= idx4;
      status   <= mtt_pkg::STAT_OK;
      armed    <= 1'b0;
      reload   <= '0;
      rearmed  <= 1'b0;
      last     <= 1'b0;
    end else if (load_st) begin
      kind     <= mtt_pkg::KIND_STATUS;
      slot_out <= res_slot;
      status   <= stat_r;
      armed    <= next_present;
      reload   <= reload_r;
      rearmed  <= rearmed_r;
      last     <= 1'b1;
    end else begin
    end
  end

  // the slot being waited on is live whenever a status word goes out
  assert property (@(posedge clk) disable iff (rst)
    (op == mtt_pkg::OP_STATUS && next_present) |-> slot_valid[next_slot])
    else $error("next slot is not live at request end");

  // a blocked expiry notice holds the scan in place
  assert property (@(posedge clk) disable iff (rst)
    (op == mtt_pkg::OP_SCAN && expire && !out_free) |=> $stable(idx))
    else $error("scan advanced past a blocked expiry");

  // a rearm always leaves the timer running
  assert property (@(posedge clk) disable iff (rst)
    (op == mtt_pkg::OP_STATUS && rearmed_r) |-> next_present)
    else $error("rearmed without a next slot");

  // arming a declared slot makes it the live next slot
  assert property (@(posedge clk) disable iff (rst)
    (op == mtt_pkg::OP_DARM) |=> (next_present && slot_valid[next_slot]))
    else $error("declare arm did not take effect");

endmodule

`default_nettype wire

// File: rtl/multiplexed_timer_table.sv
// multiplexed timer table: NUM_SLOTS software timers sharing one countdown.
// input channel (in_valid/in_ready) takes one request word: req_type, duration,
// slot and now. output channel (out_valid/out_ready) returns zero or more expiry
// notices (kind 0, in slot order) and then one status word (kind 1, last 1).
// cfg_wr_en/cfg_wr_data write the max schedulable time; write only when idle.
// one request is worked at a time; in_ready is high only between requests.
// requests that sweep the table: an expiry, a cancel of the pending slot, and
// a declare whose new deadline is sooner than the pending one; a declare first
// searches from slot 0 for the lowest free slot, through every slot when full.
// a cancel of another or an inactive slot and an unknown request do not sweep.
// the sweep over the remaining-time memory takes one slot per cycle through its
// single read port, while no expiry notice is held back by the output.
// the output register takes one word; while it is not taken the sweep holds
// on the next expiring slot and the status word waits, and a new request can
// be accepted while the last status word is still waiting.
// reset clears all slots, disarms the timer and loads the limit with 1000000.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  req_type,
  input  wire  [31:0] duration,
  input  wire  [3:0]  slot,
  input  wire  [31:0] now,
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        kind,
  output logic [3:0]  slot_out,
  output logic [1:0]  status,
  output logic        armed,
  output logic [31:0] reload,
  output logic        rearmed,
  output logic        last
);

  mtt_pkg::op_t        op;
  mtt_pkg::dp_status_t st;

  mtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .st       (st),
    .op       (op)
  );

  mtt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .st          (st),
    .req_type    (req_type),
    .duration    (duration),
    .slot        (slot),
    .now         (now),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .kind        (kind),
    .slot_out    (slot_out),
    .status      (status),
    .armed       (armed),
    .reload      (reload),
    .rearmed     (rearmed),
    .last        (last)
  );

endmodule

`default_nettype wire

// File: sim/timer_table_checker.sv
`timescale 1ns / 1ps

module timer_table_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [1:0]  req_type,
  input  wire  [31:0] duration,
  input  wire  [3:0]  slot,
  input  wire  [31:0] now,
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire         kind,
  input  wire  [3:0]  slot_out,
  input  wire  [1:0]  status,
  input  wire         armed,
  input  wire  [31:0] reload,
  input  wire         rearmed,
  input  wire         last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot_out;
    logic [1:0]  status;
    logic        armed;
    logic [31:0] reload;
    logic        rearmed;
    logic        last;
  } timer_word_t;

  // shadow copy of the slot table
  logic        live [NUM_SLOTS];
  logic [31:0] remain [NUM_SLOTS];
  logic [3:0]  soonest;
  logic        soonest_ok;
  logic [31:0] arm_time;
  logic [31:0] limit;

  timer_word_t expected_words[$];

  task automatic report_mismatch(input string msg);
    if (errors < 40) begin
      $display("%0t: timer table mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // age every live slot, queue expiry words, pick the soonest under the limit
  task automatic age_table(input logic [31:0] elapsed);
    logic [31:0] best;
    logic        found;
    logic [3:0]  pick;
    timer_word_t w;
    best  = limit;
    found = 1'b0;
    pick  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (live[i]) begin
        if (elapsed < remain[i]) begin
          remain[i] = remain[i] - elapsed;
          if (remain[i] < best) begin
            best  = remain[i];
            pick  = 4'(i);
            found = 1'b1;
          end
        end else begin
          live[i]    = 1'b0;
          w          = '0;
          w.kind     = mtt_pkg::KIND_EXPIRY;
          w.slot_out = 4'(i);
          expected_words.push_back(w);
        end
      end
    end
    soonest_ok = found;
    soonest    = found ? pick : 4'd0;
  endtask

  task automatic apply_request(input logic [1:0] rt, input logic [31:0] dur,
                               input logic [3:0] sl, input logic [31:0] nw);
    timer_word_t w;
    logic        have;
    logic [3:0]  fs;
    logic [31:0] elapsed;
    logic [31:0] new_due;
    logic [31:0] cur_due;
    w        = '0;
    w.kind   = mtt_pkg::KIND_STATUS;
    w.last   = 1'b1;
    w.status = mtt_pkg::STAT_OK;
    elapsed  = nw - arm_time;
    case (rt)
      mtt_pkg::REQ_DECLARE: begin
        have = 1'b0;
        fs   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!live[i]) begin
            fs   = 4'(i);
            have = 1'b1;
          end
        end
        if (!have) begin
          w.status = mtt_pkg::STAT_FULL;
        end else begin
          w.slot_out = fs;
          new_due    = dur + nw;
          cur_due    = remain[soonest] + arm_time;
          if (!soonest_ok || new_due < cur_due) begin
            if (soonest_ok) begin
              age_table(elapsed);
            end
            remain[fs] = dur;
            arm_time   = nw;
            soonest    = fs;
            soonest_ok = 1'b1;
            w.reload   = dur;
            w.rearmed  = 1'b1;
          end else begin
            // stored relative to the last arming time
            remain[fs] = dur + elapsed;
          end
          live[fs] = 1'b1;
        end
      end
      mtt_pkg::REQ_CANCEL: begin
        if (!live[sl]) begin
          w.status = mtt_pkg::STAT_NOT_ACTIVE;
        end else begin
          live[sl] = 1'b0;
          if (soonest_ok && soonest == sl) begin
            age_table(elapsed);
            if (soonest_ok) begin
              w.reload  = remain[soonest];
              arm_time  = nw;
              w.rearmed = 1'b1;
            end
          end
        end
      end
      mtt_pkg::REQ_EXPIRE: begin
        age_table(elapsed);
        if (soonest_ok) begin
          w.reload  = remain[soonest];
          arm_time  = nw;
          w.rearmed = 1'b1;
        end
      end
      default: begin
      end
    endcase
    w.armed = soonest_ok;
    expected_words.push_back(w);
  endtask

  task automatic check_word();
    timer_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word with nothing expected, kind %0d slot %0d",
                                kind, slot_out));
    end else begin
      want = expected_words.pop_front();
      check_field("kind", 32'(kind), 32'(want.kind));
      check_field("slot_out", 32'(slot_out), 32'(want.slot_out));
      check_field("status", 32'(status), 32'(want.status));
      check_field("armed", 32'(armed), 32'(want.armed));
      check_field("reload", reload, want.reload);
      check_field("rearmed", 32'(rearmed), 32'(want.rearmed));
      check_field("last", 32'(last), 32'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        live[i]   = 1'b0;
        remain[i] = '0;
      end
      soonest    = '0;
      soonest_ok = 1'b0;
      arm_time   = '0;
      limit      = mtt_pkg::LIMIT_RESET;
      errors     = 0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) begin
        limit = cfg_wr_data;
      end
      // words leaving now belong to requests taken at earlier edges
      if (out_valid && out_ready) begin
        check_word();
      end
      if (in_valid && in_ready) begin
        apply_request(req_type, duration, slot, now);
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: sim/tb_multiplexed_timer_table.sv
`timescale 1ns / 1ps

module tb_multiplexed_timer_table;

  localparam int NUM_SLOTS = 16;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 8;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [31:0] duration;
  logic [3:0]  slot;
  logic [31:0] now;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [3:0]  slot_out;
  logic [1:0]  status;
  logic        armed;
  logic [31:0] reload;
  logic        rearmed;
  logic        last;

  int          errors;
  int          pending;
  int          cycle_count = 0;
  int          stall_left = 0;
  logic        idle_on = 1'b1;
  logic [31:0] tnow;

  multiplexed_timer_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .duration(duration),
    .slot(slot),
    .now(now),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .slot_out(slot_out),
    .status(status),
    .armed(armed),
    .reload(reload),
    .rearmed(rearmed),
    .last(last)
  );

  timer_table_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .duration(duration),
    .slot(slot),
    .now(now),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .slot_out(slot_out),
    .status(status),
    .armed(armed),
    .reload(reload),
    .rearmed(rearmed),
    .last(last),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_multiplexed_timer_table: done, errors");
      $finish;
    end
  end

  // receiver drops out_ready in random bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_req(input logic [1:0] rt, input logic [31:0] dur,
                          input logic [3:0] sl, input logic [31:0] nw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    duration <= dur;
    slot     <= sl;
    now      <= nw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sampled on the falling edge so the checker has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int span);
    logic [1:0]  rt;
    logic [31:0] dur;
    logic [31:0] nw;
    int          roll;
    for (int k = 0; k < count; k++) begin
      tnow = tnow + 32'($urandom_range(0, 40));
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        rt = mtt_pkg::REQ_DECLARE;
      end else if (roll < 65) begin
        rt = mtt_pkg::REQ_CANCEL;
      end else if (roll < 95) begin
        rt = mtt_pkg::REQ_EXPIRE;
      end else begin
        rt = REQ_UNKNOWN;
      end
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
        dur = $urandom;
      end else if (roll == 1) begin
        dur = '0;
      end else begin
        dur = 32'($urandom_range(0, span));
      end
      // now and then a time word out of sequence
      nw = ($urandom_range(0, 39) == 0) ? $urandom : tnow;
      send_req(rt, dur, 4'($urandom_range(0, 15)), nw);
    end
  endtask

  initial begin
    logic [31:0] dur;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= mtt_pkg::REQ_DECLARE;
    duration    <= '0;
    slot        <= '0;
    now         <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(mtt_pkg::REQ_EXPIRE, '0, '0, '0);
    send_req(REQ_UNKNOWN, '1, '1, '1);
    send_req(mtt_pkg::REQ_CANCEL, 32'd77, 4'd15, 32'd3);
    // time crosses the wrap while the table fills; a zero duration expires early
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case (i)
        2: begin
          dur = 32'h8000_0000;
        end
        5: begin
          dur = 32'hFFFF_FFF0;
        end
        7: begin
          dur = '0;
        end
        default: begin
          dur = 32'(20 * (NUM_SLOTS - i));
        end
      endcase
      send_req(mtt_pkg::REQ_DECLARE, dur, 4'(i), 32'hFFFF_FFF8 + 32'(i));
    end
    send_req(mtt_pkg::REQ_DECLARE, 32'd1000, 4'd0, 32'd9);
    send_req(mtt_pkg::REQ_DECLARE, 32'd1000, 4'd0, 32'd10);
    send_req(mtt_pkg::REQ_CANCEL, 32'd0, 4'd3, 32'd11);
    send_req(mtt_pkg::REQ_CANCEL, 32'd0, 4'd14, 32'd12);
    send_req(mtt_pkg::REQ_CANCEL, 32'd0, 4'd15, 32'd13);
    send_req(mtt_pkg::REQ_EXPIRE, 32'd0, 4'd0, 32'd500);
    send_req(mtt_pkg::REQ_EXPIRE, 32'd0, 4'd0, 32'd100000);

    tnow = 32'd100000;
    random_phase(100, 300);

    wait_idle();
    write_limit(32'd1);
    random_phase(80, 300);

    wait_idle();
    write_limit('1);
    tnow = 32'hFFFF_FC00;
    random_phase(100, 5000);

    wait_idle();
    write_limit(32'($urandom_range(1, 600)));
    random_phase(90, 400);

    wait_idle();
    write_limit(mtt_pkg::LIMIT_RESET);
    idle_on <= 1'b0;
    random_phase(80, 200);

    wait_idle();
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_multiplexed_timer_table: done, clean");
    end else begin
      $display("tb_multiplexed_timer_table: done, errors");
    end
    $finish;
  end

endmodule
